FILE: sv/swsf_pkg.sv
// Package for the spellable word stream filter: beat types, config register
// indexes, letter constants and the word record passed from front to back.
// No dependencies.
package swsf_pkg;

  localparam int unsigned LETTERS        = 26;
  localparam int unsigned TALLY_W        = 5;
  localparam int unsigned COUNT_W        = 4;
  localparam int unsigned TALLY_CAP      = 16;
  localparam int unsigned LENGTH_CAP     = 255;
  localparam int unsigned COUNTS_W       = 52;
  localparam int unsigned REQ_W          = 5;
  localparam int unsigned CFG_INDEX_W    = 3;
  localparam int unsigned CFG_DATA_W     = 52;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned POSITION_BITS_DEF = 32;

  localparam logic [7:0] CHAR_A  = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_SP = 8'h20;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COUNTS_LOW  = 3'd0,
    CFG_COUNTS_HIGH = 3'd1,
    CFG_MASK        = 3'd2,
    CFG_REUSE       = 3'd3,
    CFG_REQUIRED    = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word_start;
    logic [7:0]  word_size;
  } out_item_t;

  typedef struct packed {
    logic [COUNTS_W-1:0] counts_low;
    logic [COUNTS_W-1:0] counts_high;
    logic [LETTERS-1:0]  mask;
    logic                reuse;
    logic [REQ_W-1:0]    required;
  } cfg_t;

  typedef struct packed {
    logic [LETTERS-1:0][TALLY_W-1:0] tally;
    logic [LETTERS-1:0]              seen;
    logic                            foreign;
    out_item_t                       info;
  } word_rec_t;

endpackage

FILE: sv/swsf_front.sv
// Front end: accepts text beats, classifies bytes and tracks the open word.
// Emits one word record per closed word. Depends on swsf_pkg.
module swsf_front import swsf_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  output logic      push,
  output word_rec_t rec
);

  logic [LETTERS-1:0][TALLY_W-1:0] tally_r, tally_nxt, tally_upd;
  logic [LETTERS-1:0]              seen_r, seen_nxt, seen_upd;
  logic [7:0]                      len_r, len_nxt, len_upd;
  logic                            foreign_r, foreign_nxt, foreign_upd;
  logic                            inside_r, inside_nxt;
  logic [POSITION_BITS-1:0]        start_r, start_nxt, start_upd;
  logic [POSITION_BITS-1:0]        pos_r, pos_nxt;
  logic                            sep, is_letter, close_word;
  logic [7:0]                      offset;
  logic [4:0]                      k;
  logic [63:0]                     start_ext;

  assign sep       = (item.text_byte == CHAR_LF) || (item.text_byte == CHAR_CR) ||
                     (item.text_byte == CHAR_SP);
  assign offset    = item.text_byte - CHAR_A;
  assign is_letter = (item.text_byte >= CHAR_A) && (offset < 8'(LETTERS));
  assign k         = offset[4:0];

  always_comb begin
    for (int i = 0; i < LETTERS; i++) begin
      tally_upd[i] = tally_r[i];
      seen_upd[i]  = seen_r[i];
      if (!sep && is_letter && (k == 5'(i))) begin
        seen_upd[i] = 1'b1;
        if (tally_r[i] < TALLY_W'(TALLY_CAP)) tally_upd[i] = tally_r[i] + 1'b1;
      end
    end
    foreign_upd = foreign_r | (!sep && !is_letter);
    len_upd     = (!sep && (len_r < 8'(LENGTH_CAP))) ? len_r + 8'd1 : len_r;
    start_upd   = (!sep && !inside_r) ? pos_r : start_r;
  end

  assign close_word = sep ? inside_r : item.last_byte;
  assign push       = accept && close_word;
  assign start_ext  = 64'(start_upd);

  assign rec.tally            = tally_upd;
  assign rec.seen             = seen_upd;
  assign rec.foreign          = foreign_upd;
  assign rec.info.word_start  = start_ext[31:0];
  assign rec.info.word_size   = len_upd;

  always_comb begin
    tally_nxt   = tally_r;
    seen_nxt    = seen_r;
    len_nxt     = len_r;
    foreign_nxt = foreign_r;
    inside_nxt  = inside_r;
    start_nxt   = start_r;
    pos_nxt     = pos_r;
    if (accept) begin
      pos_nxt   = item.last_byte ? '0 : pos_r + 1'b1;
      start_nxt = start_upd;
      if (sep || item.last_byte) begin
        tally_nxt   = '0;
        seen_nxt    = '0;
        len_nxt     = '0;
        foreign_nxt = 1'b0;
        inside_nxt  = 1'b0;
      end else begin
        tally_nxt   = tally_upd;
        seen_nxt    = seen_upd;
        len_nxt     = len_upd;
        foreign_nxt = foreign_upd;
        inside_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r   <= '0;
      seen_r    <= '0;
      len_r     <= '0;
      foreign_r <= 1'b0;
      inside_r  <= 1'b0;
      start_r   <= '0;
      pos_r     <= '0;
    end else begin
      tally_r   <= tally_nxt;
      seen_r    <= seen_nxt;
      len_r     <= len_nxt;
      foreign_r <= foreign_nxt;
      inside_r  <= inside_nxt;
      start_r   <= start_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

FILE: sv/swsf_queue.sv
// Two-entry queue of closed word records between front and back.
// Depends on swsf_pkg.
module swsf_queue import swsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  word_rec_t push_rec,
  input  logic      pop,
  output logic      not_empty,
  output logic      full,
  output word_rec_t head
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  word_rec_t              entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_rec;
  end

endmodule

FILE: sv/swsf_back.sv
// Back end: checks one queued word against the letter configuration and
// loads matches into the output register. Depends on swsf_pkg.
module swsf_back import swsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      rec_valid,
  input  word_rec_t rec,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [2*COUNTS_W-1:0] counts_all;
  logic                  counts_ok, req_ok, mask_ok, match;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r;

  assign counts_all = {cfg.counts_high, cfg.counts_low};

  always_comb begin
    counts_ok = 1'b1;
    req_ok    = 1'b1;
    for (int i = 0; i < LETTERS; i++) begin
      if (rec.tally[i] > {1'b0, counts_all[COUNT_W*i +: COUNT_W]}) counts_ok = 1'b0;
      if ((cfg.required == REQ_W'(i + 1)) && !rec.seen[i]) req_ok = 1'b0;
    end
  end

  assign mask_ok = ((rec.seen & ~cfg.mask) == '0);
  assign match   = !rec.foreign && req_ok && (cfg.reuse ? mask_ok : counts_ok);
  assign pop     = rec_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) out_valid_nxt = match;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop && match) out_item_r <= rec.info;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: sv/spellable_word_stream_filter.sv
// Spellable word stream filter: takes one text byte per cycle while in_stall
// is low and reports the start and length of every word that can be spelled
// from the configured letters. A result passes the word queue and the result
// register and appears on out_valid after the beat that closes its word
// (a separator, or the beat marked last_byte). The block sustains one input
// beat per cycle; in_stall rises only when the result register is stalled
// and the two-entry word queue behind it has filled. Configuration writes are
// always taken (cfg_ready stays high) and must only be made while no word is
// in flight. Depends on swsf_pkg, swsf_front, swsf_queue, swsf_back.
module spellable_word_stream_filter import swsf_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  logic      accept, push, pop, q_not_empty, q_full;
  word_rec_t push_rec, head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COUNTS_LOW:  cfg_nxt.counts_low  = cfg_data[COUNTS_W-1:0];
        CFG_COUNTS_HIGH: cfg_nxt.counts_high = cfg_data[COUNTS_W-1:0];
        CFG_MASK:        cfg_nxt.mask        = cfg_data[LETTERS-1:0];
        CFG_REUSE:       cfg_nxt.reuse       = cfg_data[0];
        CFG_REQUIRED:    cfg_nxt.required    = cfg_data[REQ_W-1:0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else        cfg_r <= cfg_nxt;
  end

  swsf_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .push   (push),
    .rec    (push_rec)
  );

  swsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (head)
  );

  swsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec_valid (q_not_empty),
    .rec       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: sv/swsf_checker.sv
// Port-level checks for the spellable word stream filter, bound to the top.
// Depends on swsf_pkg and spellable_word_stream_filter.
module swsf_checker import swsf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result beat changed");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  a_reset_queue: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.word_size != 8'd0)
    else $error("empty word reported");

endmodule

bind spellable_word_stream_filter swsf_checker u_swsf_checker (.*);
